// ===== rtl/cpv_pkg.sv =====
`timescale 1ns / 1ps

package cpv_pkg;

  // Limb width of the split multipliers and their fixed latency.
  localparam int unsigned LIMB_W  = 32;
  localparam int unsigned MUL_LAT = 3;

  // Width of the tolerance register.
  localparam int unsigned TOL_W = 31;

  // Cross product index rotation.
  localparam int unsigned XA [3] = '{1, 2, 0};
  localparam int unsigned XB [3] = '{2, 0, 1};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CHORD = 2'd1,
    ST_AREA  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

endpackage

// ===== rtl/cpv_umul.sv =====
`timescale 1ns / 1ps

// Unsigned W x W multiplier cut into limb products, row sums and a final sum.
module cpv_umul #(
  parameter int unsigned W = 67
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int unsigned L   = cpv_pkg::LIMB_W;
  localparam int unsigned NL  = (W + L - 1) / L;
  localparam int unsigned EW  = NL * L;
  localparam int unsigned PPW = 2 * L;

  logic [EW-1:0]   a_ext, b_ext;
  logic [PPW-1:0]  pp_q  [NL][NL];
  logic [2*EW-1:0] row_d [NL];
  logic [2*EW-1:0] row_q [NL];
  logic [2*EW-1:0] sum_d;
  logic [2*W-1:0]  p_q;

  assign a_ext = EW'(a_i);
  assign b_ext = EW'(b_i);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_d[i] = row_d[i] + ((2*EW)'(pp_q[i][j]) << (j * L));
      end
    end
    sum_d = '0;
    for (int i = 0; i < NL; i++) begin
      sum_d = sum_d + (row_q[i] << (i * L));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_q[i][j] <= PPW'(a_ext[i*L +: L]) * PPW'(b_ext[j*L +: L]);
        end
        row_q[i] <= row_d[i];
      end
      p_q <= sum_d[2*W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/cpv_isqrt.sv =====
`timescale 1ns / 1ps

// Integer square root, one result bit per stage, side data carried along.
module cpv_isqrt #(
  parameter int unsigned RW = 136,
  parameter int unsigned SW = 137
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned RMW = RW + 3;

  logic            v_q    [RW];
  logic [RMW-1:0]  rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SW-1:0]   side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            cv;
    logic [RMW-1:0]  crem;
    logic [RW-1:0]   croot;
    logic [2*RW-1:0] crad;
    logic [SW-1:0]   cside;
    logic [RMW-1:0]  try_rem;
    logic [RMW-1:0]  trial;
    logic            take;

    if (k == 0) begin : g_first
      assign cv    = valid_i;
      assign crem  = '0;
      assign croot = '0;
      assign crad  = rad_i;
      assign cside = side_i;
    end else begin : g_next
      assign cv    = v_q[k-1];
      assign crem  = rem_q[k-1];
      assign croot = root_q[k-1];
      assign crad  = rad_q[k-1];
      assign cside = side_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign try_rem = {crem[RMW-3:0], crad[2*RW-1 -: 2]};
    assign trial   = {1'b0, croot, 2'b01};
    assign take    = (try_rem >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (try_rem - trial) : try_rem;
        root_q[k] <= {croot[RW-2:0], take};
        rad_q[k]  <= {crad[2*RW-3:0], 2'b00};
        side_q[k] <= cside;
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

// ===== rtl/cpv_div.sv =====
`timescale 1ns / 1ps

// Rounded quotient a3 * 2^F / (a3 + root), one quotient bit per stage.
module cpv_div #(
  parameter int unsigned AW = 136,
  parameter int unsigned F  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [AW-2:0]     a3_i,
  input  logic [AW-1:0]     root_i,
  input  cpv_pkg::status_e  status_i,
  output logic              valid_o,
  output logic [F:0]        p_o,
  output cpv_pkg::status_e  status_o
);

  localparam int unsigned DNW = AW + 1;
  localparam int unsigned QB  = F + 2;
  localparam int unsigned NMW = DNW + QB + 1;

  logic [DNW-1:0] den;
  logic [NMW-1:0] num0;

  logic             v_q   [QB+1];
  logic [NMW-1:0]   num_q [QB+1];
  logic [DNW:0]     d2_q  [QB+1];
  logic [QB-1:0]    quo_q [QB+1];
  cpv_pkg::status_e st_q  [QB+1];

  assign den  = DNW'(a3_i) + DNW'(root_i);
  // Add den so that the truncating divide by 2*den rounds to nearest.
  assign num0 = (NMW'(a3_i) << (F + 1)) + NMW'(den);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num0;
      d2_q[0]  <= {den, 1'b0};
      quo_q[0] <= '0;
      st_q[0]  <= status_i;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    localparam int unsigned B = QB - k;
    logic [NMW-1:0] sh;
    logic           take;

    assign sh   = NMW'(d2_q[k-1]) << B;
    assign take = (num_q[k-1] >= sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= take ? (num_q[k-1] - sh) : num_q[k-1];
        d2_q[k]  <= d2_q[k-1];
        quo_q[k] <= quo_q[k-1] | (QB'(take) << B);
        st_q[k]  <= st_q[k-1];
      end
    end
  end

  assign valid_o  = v_q[QB];
  assign status_o = st_q[QB];
  assign p_o      = (st_q[QB] == cpv_pkg::ST_OK) ? quo_q[QB][F:0] : '0;

endmodule

// ===== rtl/conic_p_value_from_point_top.sv =====
`timescale 1ns / 1ps

// Conic shoulder p value from four points A, B, C, D in signed fixed point.
// Fully pipelined: one beat is taken every cycle while in_stall_o is low.
// The integer square root, AW = 4*COORD_WIDTH + 8 bits wide, gives one root
// bit per stage and makes up most of the pipeline. An output skid register
// lets one more beat in while the output is stalled. Status: 0 ok, 1 chord
// |AC| below tolerance, 2 a part area below tolerance, 3 p undefined;
// p_value is 0 unless ok.
// Write tolerance only while no beat is in flight.
module conic_p_value_from_point_top #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cpv_pkg::TOL_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]      start_x_i,
  input  logic signed [COORD_WIDTH-1:0]      start_y_i,
  input  logic signed [COORD_WIDTH-1:0]      start_z_i,
  input  logic signed [COORD_WIDTH-1:0]      hard_x_i,
  input  logic signed [COORD_WIDTH-1:0]      hard_y_i,
  input  logic signed [COORD_WIDTH-1:0]      hard_z_i,
  input  logic signed [COORD_WIDTH-1:0]      end_x_i,
  input  logic signed [COORD_WIDTH-1:0]      end_y_i,
  input  logic signed [COORD_WIDTH-1:0]      end_z_i,
  input  logic signed [COORD_WIDTH-1:0]      mid_x_i,
  input  logic signed [COORD_WIDTH-1:0]      mid_y_i,
  input  logic signed [COORD_WIDTH-1:0]      mid_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [FRAC_BITS:0]                 p_value_o,
  output logic [1:0]                         status_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned TW   = cpv_pkg::TOL_W;
  localparam int unsigned ML   = cpv_pkg::MUL_LAT;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned PW   = 2 * DW + 1;
  localparam int unsigned AW   = 2 * PW + 2;
  localparam int unsigned CHW  = 2 * W + 3;
  localparam int unsigned CMW  = (CHW > 2 * TW) ? CHW : 2 * TW;
  localparam int unsigned LW   = ((AW > TW + 3 * F) ? AW : TW + 3 * F) + 1;
  localparam int unsigned SW   = AW + 1;

  logic adv;

  // Tolerance register and its square.
  logic [TW-1:0]   tol_q;
  logic [2*TW-1:0] tolsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= TW'(1);
      tolsq_q <= (2*TW)'(1);
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      tolsq_q <= (2*TW)'(tol_q) * (2*TW)'(tol_q);
    end
  end

  // Stage 1: difference vectors.
  logic signed [W-1:0]  pa [3], pb [3], pc [3], pd [3];
  logic signed [DW-1:0] ad_q [3], bd_q [3], cd_q [3], ac_q [3];
  logic                 v1_q;

  assign pa = '{start_x_i, start_y_i, start_z_i};
  assign pb = '{hard_x_i, hard_y_i, hard_z_i};
  assign pc = '{end_x_i, end_y_i, end_z_i};
  assign pd = '{mid_x_i, mid_y_i, mid_z_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ad_q[i] <= {pa[i][W-1], pa[i]} - {pd[i][W-1], pd[i]};
        bd_q[i] <= {pb[i][W-1], pb[i]} - {pd[i][W-1], pd[i]};
        cd_q[i] <= {pc[i][W-1], pc[i]} - {pd[i][W-1], pd[i]};
        ac_q[i] <= {pa[i][W-1], pa[i]} - {pc[i][W-1], pc[i]};
      end
    end
  end

  // Stage 2: cross product terms and chord squares.
  logic signed [2*DW-1:0] pnl_q [3], pnr_q [3];
  logic signed [2*DW-1:0] c1l_q [3], c1r_q [3];
  logic signed [2*DW-1:0] c2l_q [3], c2r_q [3];
  logic signed [2*DW-1:0] chsq_q [3];
  logic                   v2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pnl_q[i]  <= cd_q[cpv_pkg::XA[i]] * ad_q[cpv_pkg::XB[i]];
        pnr_q[i]  <= cd_q[cpv_pkg::XB[i]] * ad_q[cpv_pkg::XA[i]];
        c1l_q[i]  <= ad_q[cpv_pkg::XA[i]] * bd_q[cpv_pkg::XB[i]];
        c1r_q[i]  <= ad_q[cpv_pkg::XB[i]] * bd_q[cpv_pkg::XA[i]];
        c2l_q[i]  <= bd_q[cpv_pkg::XA[i]] * cd_q[cpv_pkg::XB[i]];
        c2r_q[i]  <= bd_q[cpv_pkg::XB[i]] * cd_q[cpv_pkg::XA[i]];
        chsq_q[i] <= ac_q[i] * ac_q[i];
      end
    end
  end

  // Stage 3: normal, two cross products, chord test.
  logic signed [PW-1:0] pn_q [3], c1_q [3], c2_q [3];
  logic [CHW-1:0]       chsum;
  logic                 chord3_q;
  logic                 v3_q;

  assign chsum = CHW'($unsigned(chsq_q[0])) + CHW'($unsigned(chsq_q[1]))
               + CHW'($unsigned(chsq_q[2]));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pn_q[i] <= PW'(pnl_q[i]) - PW'(pnr_q[i]);
        c1_q[i] <= PW'(c1l_q[i]) - PW'(c1r_q[i]);
        c2_q[i] <= PW'(c2l_q[i]) - PW'(c2r_q[i]);
      end
      chord3_q <= (CMW'(chsum) < CMW'(tolsq_q));
    end
  end

  // Stage 4: magnitudes and term signs for the dot products.
  logic [PW-1:0] mpn_q [3], mc1_q [3], mc2_q [3];
  logic [2:0]    sg1_q, sg2_q;
  logic          chord4_q;
  logic          v4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mpn_q[i] <= pn_q[i][PW-1] ? PW'(-pn_q[i]) : PW'(pn_q[i]);
        mc1_q[i] <= c1_q[i][PW-1] ? PW'(-c1_q[i]) : PW'(c1_q[i]);
        mc2_q[i] <= c2_q[i][PW-1] ? PW'(-c2_q[i]) : PW'(c2_q[i]);
        sg1_q[i] <= c1_q[i][PW-1] ^ pn_q[i][PW-1];
        sg2_q[i] <= c2_q[i][PW-1] ^ pn_q[i][PW-1];
      end
      chord4_q <= chord3_q;
    end
  end

  // Dot product terms.
  logic [2*PW-1:0] pr1 [3], pr2 [3], pr3 [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    cpv_umul #(.W(PW)) u_mul1 (
      .clk_i (clk_i), .en_i (adv), .a_i (mc1_q[i]), .b_i (mpn_q[i]), .p_o (pr1[i])
    );
    cpv_umul #(.W(PW)) u_mul2 (
      .clk_i (clk_i), .en_i (adv), .a_i (mc2_q[i]), .b_i (mpn_q[i]), .p_o (pr2[i])
    );
    cpv_umul #(.W(PW)) u_mul3 (
      .clk_i (clk_i), .en_i (adv), .a_i (mpn_q[i]), .b_i (mpn_q[i]), .p_o (pr3[i])
    );
  end

  logic       dv_q     [ML];
  logic       dchord_q [ML];
  logic [2:0] dsg1_q   [ML];
  logic [2:0] dsg2_q   [ML];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dchord_q[0] <= chord4_q;
      dsg1_q[0]   <= sg1_q;
      dsg2_q[0]   <= sg2_q;
      for (int k = 1; k < ML; k++) begin
        dchord_q[k] <= dchord_q[k-1];
        dsg1_q[k]   <= dsg1_q[k-1];
        dsg2_q[k]   <= dsg2_q[k-1];
      end
    end
  end

  // Stage 8: part areas.
  logic signed [AW-1:0] a1_d, a2_d, a3_d;
  logic signed [AW-1:0] t1, t2;
  logic signed [AW-1:0] a1_q, a2_q, a3_q;
  logic                 chord8_q;
  logic                 v8_q;

  always_comb begin
    a1_d = '0;
    a2_d = '0;
    a3_d = '0;
    t1   = '0;
    t2   = '0;
    for (int i = 0; i < 3; i++) begin
      t1   = $signed(AW'(pr1[i]));
      t2   = $signed(AW'(pr2[i]));
      a1_d = dsg1_q[ML-1][i] ? (a1_d - t1) : (a1_d + t1);
      a2_d = dsg2_q[ML-1][i] ? (a2_d - t2) : (a2_d + t2);
      a3_d = a3_d + $signed(AW'(pr3[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      a3_q     <= a3_d;
      chord8_q <= dchord_q[ML-1];
    end
  end

  // Stage 9: area tests and status.
  logic signed [LW-1:0] lim;
  cpv_pkg::status_e     st9_d, st9_q;
  logic [AW-2:0]        a1m_q, a2m_q, a3m_q;
  logic                 v9_q;

  assign lim = $signed(LW'(tol_q) << (3 * F));

  always_comb begin
    if (chord8_q) begin
      st9_d = cpv_pkg::ST_CHORD;
    end else if ((LW'(a1_q) < lim) || (LW'(a2_q) < lim) || (LW'(a3_q) < lim)) begin
      st9_d = cpv_pkg::ST_AREA;
    end else if (a3_q == '0) begin
      st9_d = cpv_pkg::ST_RANGE;
    end else begin
      st9_d = cpv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st9_q <= st9_d;
      a1m_q <= a1_q[AW-2:0];
      a2m_q <= a2_q[AW-2:0];
      a3m_q <= a3_q[AW-2:0];
    end
  end

  // 4 * area1 * area2 under the root.
  logic [2*AW-3:0]  prod;
  logic             pv_q    [ML];
  cpv_pkg::status_e pst_q   [ML];
  logic [AW-2:0]    pa3_q   [ML];

  cpv_umul #(.W(AW-1)) u_prod (
    .clk_i (clk_i), .en_i (adv), .a_i (a1m_q), .b_i (a2m_q), .p_o (prod)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pst_q[0] <= st9_q;
      pa3_q[0] <= a3m_q;
      for (int k = 1; k < ML; k++) begin
        pst_q[k] <= pst_q[k-1];
        pa3_q[k] <= pa3_q[k-1];
      end
    end
  end

  // Valid bits of the front stages and the multiplier shift lines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      for (int k = 0; k < ML; k++) begin
        dv_q[k] <= 1'b0;
        pv_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      dv_q[0] <= v4_q;
      v8_q    <= dv_q[ML-1];
      v9_q    <= v8_q;
      pv_q[0] <= v9_q;
      for (int k = 1; k < ML; k++) begin
        dv_q[k] <= dv_q[k-1];
        pv_q[k] <= pv_q[k-1];
      end
    end
  end

  // Square root and division.
  logic             sq_v;
  logic [AW-1:0]    root;
  logic [SW-1:0]    sq_side;
  logic             dv_v;
  logic [F:0]       dv_p;
  cpv_pkg::status_e dv_st;

  cpv_isqrt #(.RW(AW), .SW(SW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pv_q[ML-1]),
    .rad_i   ({prod, 2'b00}),
    .side_i  ({pst_q[ML-1], pa3_q[ML-1]}),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (sq_side)
  );

  cpv_div #(.AW(AW), .F(F)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (sq_v),
    .a3_i     (sq_side[AW-2:0]),
    .root_i   (root),
    .status_i (cpv_pkg::status_e'(sq_side[SW-1:AW-1])),
    .valid_o  (dv_v),
    .p_o      (dv_p),
    .status_o (dv_st)
  );

  // Output register with one skid entry.
  logic             out_v_q, sk_v_q;
  logic [F:0]       out_p_q, sk_p_q;
  cpv_pkg::status_e out_st_q, sk_st_q;

  assign adv = ~sk_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (out_v_q && out_stall_i) begin
      if (dv_v && !sk_v_q) begin
        sk_v_q <= 1'b1;
      end
    end else if (sk_v_q) begin
      out_v_q <= 1'b1;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && out_stall_i) begin
      // Hold the output; catch the beat leaving the pipeline.
      if (!sk_v_q) begin
        sk_p_q  <= dv_p;
        sk_st_q <= dv_st;
      end
    end else if (sk_v_q) begin
      out_p_q  <= sk_p_q;
      out_st_q <= sk_st_q;
    end else begin
      out_p_q  <= dv_p;
      out_st_q <= dv_st;
    end
  end

  assign in_stall_o  = sk_v_q;
  assign out_valid_o = out_v_q;
  assign p_value_o   = out_p_q;
  assign status_o    = out_st_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> out_v_q)
    else $error("skid entry filled while output register empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  a_p_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_st_q != cpv_pkg::ST_OK)) |-> (out_p_q == '0))
    else $error("nonzero p with error status");

  a_p_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_st_q == cpv_pkg::ST_OK)) |-> (out_p_q <= {1'b1, {F{1'b0}}}))
    else $error("p above one");

endmodule

// ===== tb/sv/conic_p_value_from_point_checker.sv =====
`timescale 1ns / 1ps

module conic_p_value_from_point_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [383:0] query_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [16:0] p_value_i,
  input  logic [1:0]  status_i,
  output int          fails_o,
  output int          pending_o,
  output int          checked_o,
  output int          ok_count_o
);

  localparam int WW = 320;
  typedef logic signed [WW-1:0] wide_t;

  typedef struct {
    logic [16:0]      p_value;
    cpv_pkg::status_e status;
  } p_result_t;

  p_result_t   expected_q[$];
  logic [30:0] tol;

  function automatic void cross3(input wide_t u[3], input wide_t v[3], output wide_t r[3]);
    r[0] = u[1] * v[2] - u[2] * v[1];
    r[1] = u[2] * v[0] - u[0] * v[2];
    r[2] = u[0] * v[1] - u[1] * v[0];
  endfunction

  function automatic wide_t dot3(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic p_result_t predict_p(input logic [383:0] pts, input logic [30:0] tl);
    wide_t pa[3], pb[3], pc[3], pd[3], ad[3], bd[3], cd[3], nrm[3], cr[3];
    wide_t chord, tolw, lim, a1, a2, a3, den, num, quo;
    logic [WW-1:0] prod, root, trial;
    p_result_t res;
    res.p_value = '0;
    tolw = '0;
    tolw[30:0] = tl;
    chord = '0;
    for (int i = 0; i < 3; i++) begin
      pa[i] = wide_t'($signed(pts[i*32 +: 32]));
      pb[i] = wide_t'($signed(pts[(3+i)*32 +: 32]));
      pc[i] = wide_t'($signed(pts[(6+i)*32 +: 32]));
      pd[i] = wide_t'($signed(pts[(9+i)*32 +: 32]));
      chord += (pa[i] - pc[i]) * (pa[i] - pc[i]);
      ad[i] = pa[i] - pd[i];
      bd[i] = pb[i] - pd[i];
      cd[i] = pc[i] - pd[i];
    end
    if (chord < tolw * tolw) begin
      res.status = cpv_pkg::ST_CHORD;
      return res;
    end
    cross3(cd, ad, nrm);
    cross3(ad, bd, cr);
    a1 = dot3(cr, nrm);
    cross3(bd, cd, cr);
    a2 = dot3(cr, nrm);
    a3 = dot3(nrm, nrm);
    lim = tolw <<< 48;
    if (a1 < lim || a2 < lim || a3 < lim) begin
      res.status = cpv_pkg::ST_AREA;
      return res;
    end
    if (a3 == 0) begin
      res.status = cpv_pkg::ST_RANGE;
      return res;
    end
    prod = (a1 * a2) << 2;
    root = '0;
    for (int k = 150; k >= 0; k--) begin
      trial = root;
      trial[k] = 1'b1;
      if (trial * trial <= prod) root = trial;
    end
    den = a3 + wide_t'(root);
    num = (a3 <<< 17) + den;
    quo = num / (den <<< 1);
    res.p_value = quo[16:0];
    res.status = cpv_pkg::ST_OK;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    p_result_t exp_r;
    int nerr;
    if (!rst_ni) begin
      expected_q.delete();
      tol <= 31'd1;
      fails_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      ok_count_o <= 0;
    end else begin
      if (cfg_we_i) tol <= cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_p(query_i, tol));
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        nerr = 0;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: p_value %0d status %0d", p_value_i, status_i);
          nerr++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.status == cpv_pkg::ST_OK) ok_count_o <= ok_count_o + 1;
          if (p_value_i !== exp_r.p_value) begin
            $error("p_value: expected %0d, actual %0d", exp_r.p_value, p_value_i);
            nerr++;
          end
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, status_i);
            nerr++;
          end
        end
        if (nerr != 0) fails_o <= fails_o + nerr;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== tb/sv/conic_p_value_from_point_top_test.sv =====
`timescale 1ns / 1ps

module conic_p_value_from_point_top_test;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [383:0] query = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [16:0] p_value_o;
  logic [1:0]  status_o;

  int fails, pending, checked, ok_count;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_cnt = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  bit stuck = 1'b0;

  always #6 clk_i = ~clk_i;

  conic_p_value_from_point_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .start_x_i(query[0*32 +: 32]), .start_y_i(query[1*32 +: 32]),
    .start_z_i(query[2*32 +: 32]), .hard_x_i(query[3*32 +: 32]),
    .hard_y_i(query[4*32 +: 32]), .hard_z_i(query[5*32 +: 32]),
    .end_x_i(query[6*32 +: 32]), .end_y_i(query[7*32 +: 32]),
    .end_z_i(query[8*32 +: 32]), .mid_x_i(query[9*32 +: 32]),
    .mid_y_i(query[10*32 +: 32]), .mid_z_i(query[11*32 +: 32]),
    .out_valid_o, .out_stall_i, .p_value_o, .status_o
  );

  conic_p_value_from_point_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_i(in_stall_o),
    .query_i({DUT.mid_z_i, DUT.mid_y_i, DUT.mid_x_i, DUT.end_z_i, DUT.end_y_i,
              DUT.end_x_i, DUT.hard_z_i, DUT.hard_y_i, DUT.hard_x_i, DUT.start_z_i,
              DUT.start_y_i, DUT.start_x_i}),
    .out_valid_i(out_valid_o), .out_stall_i, .p_value_i(p_value_o), .status_i(status_o),
    .fails_o(fails), .pending_o(pending), .checked_o(checked), .ok_count_o(ok_count)
  );

  // Receiver: stall pattern changes at random; one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    #(12ns * 2_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [383:0] make_query(input logic [31:0] c[12]);
    logic [383:0] v;
    for (int i = 0; i < 12; i++) v[i*32 +: 32] = c[i];
    return v;
  endfunction

  function automatic longint rand_coord(input int sh);
    return longint'($urandom_range(0, (32'd1 << (sh + 1)) - 1)) - (longint'(1) << sh);
  endfunction

  function automatic logic [383:0] rand_query();
    logic [31:0] c[12];
    longint pa[3], pb[3], pc[3];
    int mode, sh, wa, wb, wc;
    mode = $urandom_range(0, 9);
    sh = $urandom_range(2, 29);
    for (int i = 0; i < 3; i++) begin
      pa[i] = rand_coord(sh);
      pb[i] = rand_coord(sh);
      pc[i] = rand_coord(sh);
      c[i] = pa[i][31:0];
      c[3+i] = pb[i][31:0];
      c[6+i] = pc[i][31:0];
    end
    wa = $urandom_range(1, 255);
    wb = $urandom_range(1, 255);
    wc = $urandom_range(1, 255);
    for (int i = 0; i < 3; i++)
      c[9+i] = 32'((wa * pa[i] + wb * pb[i] + wc * pc[i]) / (wa + wb + wc));
    if (mode <= 1) begin
      for (int i = 0; i < 12; i++) c[i] = $urandom;
    end else if (mode == 8) begin
      // drop D onto a corner or onto an edge
      for (int i = 0; i < 3; i++)
        c[9+i] = ($urandom_range(0, 1) == 0) ? c[i] : 32'((pb[i] + pc[i]) / 2);
    end else if (mode == 9) begin
      for (int i = 0; i < 3; i++) c[6+i] = c[i] + 32'($urandom_range(0, 3));
    end
    return make_query(c);
  endfunction

  task automatic send(input logic [383:0] q, input int gap);
    in_valid_i <= 1'b1;
    query <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      return $urandom_range(0, 6);
    end
    burst_left--;
    return 0;
  endfunction

  // Caller has already dropped valid.
  task automatic drain_all();
    int waited;
    waited = 0;
    @(posedge clk_i);
    while (pending != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending != 0) stuck = 1'b1;
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_tol(input logic [30:0] v);
    drain_all();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_fixed(input logic [31:0] c[12]);
    send(make_query(c), $urandom_range(0, 2) + 1);
  endtask

  task automatic chord_edge(input logic [30:0] tl);
    logic [31:0] c[12];
    for (int i = 0; i < 12; i++) c[i] = '0;
    c[4] = 32'h0001_0000;
    c[6] = {1'b0, tl} - 32'd1;
    c[10] = 32'h0000_1000;
    send_fixed(c);
    c[6] = {1'b0, tl};
    send_fixed(c);
  endtask

  task automatic run_random(input int n, input bit with_hold);
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == 20) hold_req <= 1'b1;
      if (k == n / 2) begin
        send(rand_query(), 1);
        drain_all();
      end else begin
        send(rand_query(), (k == n - 1) ? 1 : next_gap());
      end
    end
  endtask

  initial begin
    logic [31:0] c[12];
    logic [30:0] tols[5];
    tols = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd1, 31'd0};
    tols[4] = 31'($urandom_range(1, 1 << 20));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero: chord too short
    for (int i = 0; i < 12; i++) c[i] = '0;
    send_fixed(c);
    // coordinate extremes
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h7FFF_FFFF;
      c[3+i] = (i == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      c[6+i] = 32'h8000_0000;
      c[9+i] = '0;
    end
    send_fixed(c);
    for (int i = 0; i < 3; i++) begin
      c[i] = 32'h8000_0000;
      c[6+i] = 32'h7FFF_FFFF;
    end
    send_fixed(c);
    // plain triangle, D inside
    for (int i = 0; i < 12; i++) c[i] = '0;
    c[3] = 32'h0001_0000; c[4] = 32'h0001_0000; c[6] = 32'h0002_0000;
    c[9] = 32'h0001_0000; c[10] = 32'h0000_8000;
    send_fixed(c);
    // D outside: negative area
    c[10] = 32'hFFFF_8000;
    send_fixed(c);
    // D on the chord: zero normal
    c[10] = '0;
    send_fixed(c);
    // D equal to A
    c[9] = '0;
    send_fixed(c);
    // C equal to A
    c[6] = '0; c[9] = 32'h0000_4000; c[10] = 32'h0000_4000;
    send_fixed(c);
    chord_edge(31'd1);
    for (int k = 0; k < 12; k++) send(rand_query(), (k == 11) ? 1 : next_gap());

    for (int ph = 0; ph < 5; ph++) begin
      write_tol(tols[ph]);
      if (tols[ph] == 0) begin
        // every point alike: undefined p
        for (int i = 0; i < 12; i++) c[i] = 32'h0003_0000;
        send_fixed(c);
        // D midway on BC: p of one
        for (int i = 0; i < 12; i++) c[i] = '0;
        c[3] = 32'h0001_0000; c[4] = 32'h0001_0000; c[6] = 32'h0002_0000;
        c[9] = 32'h0001_8000; c[10] = 32'h0000_8000;
        send_fixed(c);
      end else begin
        chord_edge(tols[ph]);
      end
      run_random(285, ph == 2);
    end

    drain_all();
    $display("Checked %0d result beats, %0d with a valid p, across six tolerance settings",
             checked, ok_count);
    $display("with random sender gaps, receiver stalls, one long hold-off and drain pauses.");
    if (fails == 0 && !stuck) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
